// ===== hw/rtl/mtep_pkg.sv =====
// Shared types, phase and kind codes, and constants for the MIDI track event parser.
// No dependencies; imported by mtep_step and midi_track_event_parser.
package mtep_pkg;

    // Parse phases
    localparam logic [3:0] PH_DELTA     = 4'd0;
    localparam logic [3:0] PH_EVENT     = 4'd1;
    localparam logic [3:0] PH_DATA1     = 4'd2;
    localparam logic [3:0] PH_DATA2     = 4'd3;
    localparam logic [3:0] PH_SKIP_CC   = 4'd4;
    localparam logic [3:0] PH_SYSEX_LEN = 4'd5;
    localparam logic [3:0] PH_SKIP      = 4'd6;
    localparam logic [3:0] PH_META_TYPE = 4'd7;
    localparam logic [3:0] PH_META_LEN  = 4'd8;
    localparam logic [3:0] PH_META_DATA = 4'd9;

    // Result kinds
    localparam logic [2:0] KIND_DELTA    = 3'd0;
    localparam logic [2:0] KIND_CHANNEL  = 3'd1;
    localparam logic [2:0] KIND_TEMPO    = 3'd2;
    localparam logic [2:0] KIND_TIME_SIG = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW = 3'd5;

    localparam logic [27:0] VLQ_MAX       = 28'h0FFFFFFF;
    localparam logic [7:0]  STATUS_MIN    = 8'h80;
    localparam logic [7:0]  STATUS_SYS    = 8'hF0;
    localparam logic [7:0]  STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0]  STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0]  STATUS_META   = 8'hFF;
    localparam logic [7:0]  META_EOT      = 8'h2F;
    localparam logic [7:0]  META_TEMPO    = 8'h51;
    localparam logic [7:0]  META_TIME_SIG = 8'h58;
    localparam logic [7:0]  CC_EXTRA_SKIP = 8'h7E;
    localparam logic [3:0]  CMD_CONTROL   = 4'hB;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  running_status;
        logic [27:0] vlq_acc;
        logic [2:0]  vlq_cnt;
        logic [27:0] skip_rem;
        logic [7:0]  meta_type;
        logic [7:0]  meta_index;
        logic [23:0] meta_value;
        logic [7:0]  first_hold;
        logic        track_active;
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [3:0]  command;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [27:0] value;
    } result_t;

    function automatic state_t state_reset();
        state_t s;
        s              = '0;
        s.phase        = PH_DELTA;
        s.track_active = 1'b1;
        return s;
    endfunction

    // Data bytes per channel command (high nibble of status)
    function automatic logic [1:0] data_count(input logic [3:0] cmd);
        logic [1:0] n;
        case (cmd)
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
            4'hC, 4'hD:                   n = 2'd1;
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/mtep_step.sv =====
// Next-state and result logic for one track byte of the MIDI track parser.
// Depends on mtep_pkg.
module mtep_step (
    input  mtep_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              new_track,
    output mtep_pkg::state_t  nxt,
    output mtep_pkg::result_t res
);
    import mtep_pkg::*;

    state_t      base;
    logic [27:0] f_acc;
    logic [2:0]  f_cnt;
    logic        f_ovf;
    logic        f_done;
    logic        do_delta;
    logic        do_data1;
    logic        do_chan;
    logic [7:0]  chan_first;
    logic [7:0]  chan_second;
    logic [27:0] skip_dec;
    logic [7:0]  meta_idx_inc;

    always_comb
    begin
        base = new_track ? state_reset() : cur;
    end

    // Variable-length quantity feed; saturates on the fifth byte
    always_comb
    begin
        f_acc = base.vlq_acc;
        f_cnt = base.vlq_cnt;
        f_ovf = 1'b0;
        if (base.vlq_cnt >= 3'd4)
        begin
            if (base.vlq_cnt == 3'd4)
            begin
                f_cnt = 3'd5;
                f_acc = VLQ_MAX;
                f_ovf = 1'b1;
            end
        end
        else
        begin
            f_acc = {base.vlq_acc[20:0], data_byte[6:0]};
            f_cnt = base.vlq_cnt + 3'd1;
        end
        f_done = ~data_byte[7];
    end

    assign skip_dec     = (base.skip_rem != 28'd0) ? base.skip_rem - 28'd1 : 28'd0;
    assign meta_idx_inc = (base.meta_index != 8'hFF) ? base.meta_index + 8'd1 : 8'hFF;

    always_comb
    begin
        nxt         = base;
        res         = '0;
        do_delta    = 1'b0;
        do_data1    = 1'b0;
        do_chan     = 1'b0;
        chan_first  = base.first_hold;
        chan_second = 8'd0;

        if (base.track_active)
        begin
            case (base.phase)
                PH_DELTA:
                    do_delta = 1'b1;
                PH_EVENT:
                begin
                    if (data_byte < STATUS_MIN)
                    begin
                        if (base.running_status == 8'd0)
                            do_delta = 1'b1;
                        else
                            do_data1 = 1'b1;
                    end
                    else if (data_byte < STATUS_SYS)
                    begin
                        nxt.running_status = data_byte;
                        nxt.phase          = PH_DATA1;
                    end
                    else if (data_byte == STATUS_SYSEX || data_byte == STATUS_ESCAPE)
                    begin
                        nxt.vlq_acc = 28'd0;
                        nxt.vlq_cnt = 3'd0;
                        nxt.phase   = PH_SYSEX_LEN;
                    end
                    else if (data_byte == STATUS_META)
                        nxt.phase = PH_META_TYPE;
                    else
                        nxt.phase = PH_DELTA;
                end
                PH_DATA1:
                    do_data1 = 1'b1;
                PH_DATA2:
                begin
                    do_chan     = 1'b1;
                    chan_second = data_byte;
                end
                PH_SKIP_CC:
                    nxt.phase = PH_DELTA;
                PH_SYSEX_LEN:
                begin
                    nxt.vlq_acc = f_acc;
                    nxt.vlq_cnt = f_cnt;
                    if (f_done)
                    begin
                        nxt.skip_rem = f_acc;
                        nxt.vlq_acc  = 28'd0;
                        nxt.vlq_cnt  = 3'd0;
                        nxt.phase    = (f_acc == 28'd0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    nxt.skip_rem = skip_dec;
                    if (skip_dec == 28'd0)
                        nxt.phase = PH_DELTA;
                end
                PH_META_TYPE:
                begin
                    nxt.meta_type = data_byte;
                    nxt.phase     = PH_META_LEN;
                end
                PH_META_LEN:
                begin
                    if (base.meta_type == META_EOT)
                    begin
                        nxt.track_active = 1'b0;
                        nxt.phase        = PH_DELTA;
                        res.valid        = 1'b1;
                        res.kind         = KIND_END;
                    end
                    else
                    begin
                        nxt.skip_rem   = {20'd0, data_byte};
                        nxt.meta_index = 8'd0;
                        nxt.meta_value = 24'd0;
                        nxt.phase      = (data_byte == 8'd0) ? PH_DELTA : PH_META_DATA;
                    end
                end
                PH_META_DATA:
                begin
                    nxt.meta_index = meta_idx_inc;
                    if (base.meta_type == META_TEMPO && meta_idx_inc <= 8'd3)
                    begin
                        nxt.meta_value = {base.meta_value[15:0], data_byte};
                        if (meta_idx_inc == 8'd3)
                        begin
                            res.valid = 1'b1;
                            res.kind  = KIND_TEMPO;
                            res.value = {4'd0, base.meta_value[15:0], data_byte};
                        end
                    end
                    else if (base.meta_type == META_TIME_SIG)
                    begin
                        if (meta_idx_inc == 8'd1)
                            nxt.first_hold = data_byte;
                        else if (meta_idx_inc == 8'd2)
                        begin
                            res.valid       = 1'b1;
                            res.kind        = KIND_TIME_SIG;
                            res.first_data  = base.first_hold;
                            res.second_data = data_byte;
                        end
                    end
                    nxt.skip_rem = skip_dec;
                    if (skip_dec == 28'd0)
                        nxt.phase = PH_DELTA;
                end
                default:
                    nxt.phase = PH_DELTA;
            endcase
        end

        if (do_delta)
        begin
            nxt.vlq_acc = f_acc;
            nxt.vlq_cnt = f_cnt;
            if (f_ovf)
            begin
                res.valid = 1'b1;
                res.kind  = KIND_OVERFLOW;
                res.value = VLQ_MAX;
            end
            if (f_done)
            begin
                if (!f_ovf && f_cnt <= 3'd4)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_DELTA;
                    res.value = f_acc;
                end
                nxt.vlq_acc = 28'd0;
                nxt.vlq_cnt = 3'd0;
                nxt.phase   = PH_EVENT;
            end
        end

        if (do_data1)
        begin
            nxt.first_hold = data_byte;
            chan_first     = data_byte;
            if (data_count(base.running_status[7:4]) == 2'd1)
                do_chan = 1'b1;
            else
                nxt.phase = PH_DATA2;
        end

        if (do_chan)
        begin
            if (base.running_status[7:4] == CMD_CONTROL && chan_first == CC_EXTRA_SKIP)
                nxt.phase = PH_SKIP_CC;
            else
                nxt.phase = PH_DELTA;
            res.valid       = 1'b1;
            res.kind        = KIND_CHANNEL;
            res.channel     = base.running_status[3:0];
            res.command     = base.running_status[7:4];
            res.first_data  = chan_first;
            res.second_data = chan_second;
            res.value       = 28'd0;
        end
    end

endmodule

// ===== hw/rtl/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: input register, parser state, result register.
// Depends on mtep_pkg and mtep_step.

// One track byte per item in, at most one event item out per byte. Throughput is
// one byte per clock while the output is not blocked: a byte sits in the input register
// while mtep_step computes the next parser state and any result, and the result is
// written to the output register on the same edge as the parser state. An accepted
// byte is first captured in the input register; its result then lands in the output register.
// The input side keeps accepting while a result waits,
// as long as the pending byte can move forward; it stalls only when the input
// register is full and the output register holds an item not yet taken. Set
// s_axis_tuser on the first byte of a track to clear running status and the parser.
// After an end-of-track meta event all bytes are dropped until the next new track.
// Result kinds: 0 delta, 1 channel message, 2 tempo, 3 time signature,
// 4 end of track, 5 delta overflow (value saturates at 0x0FFFFFFF).
module midi_track_event_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] new_track
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [3:0] channel, [7:4] command,
                                        // [15:8] first_data, [23:16] second_data,
                                        // [51:24] value, [55:52] zero
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import mtep_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;

    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;

    logic       advance;
    logic       in_accept;

    // pending byte moves on when the output slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mtep_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .new_track (in_new_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    assign out_valid_next = advance ? step_res.valid : (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= state_reset();
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_new_reg  <= s_axis_tuser[0];
        end
        if (advance && step_res.valid)
            out_res_reg <= step_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {4'd0, out_res_reg.value, out_res_reg.second_data,
                            out_res_reg.first_data, out_res_reg.command,
                            out_res_reg.channel};

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (out_valid_reg && !m_axis_tready && in_valid_reg))
        else $error("input stalled without a blocked result");

    // a produced result shows up on the output next cycle
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid) |=> m_axis_tvalid)
        else $error("result lost");

    // end of track stops the parser
    a_eot_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid && step_res.kind == KIND_END) |=> !state_reg.track_active)
        else $error("track still active after end of track");

    // vlq byte count saturates at five
    a_vlq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.vlq_cnt <= 3'd5)
        else $error("vlq byte count out of range");

    // an inactive track emits nothing unless a new track starts
    a_inactive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !state_reg.track_active && !in_new_reg) |=> $stable(state_reg))
        else $error("inactive track changed state");

endmodule
